// ===== rtl/cbt_pkg.sv =====
// shared types, constants and fixed-point helpers for the cubic bezier tessellator
// no dependencies; used by every module of the block

package cbt_pkg;

   // default configuration of the block
   localparam int unsigned MAX_SEGMENTS_DEF = 63;
   localparam int unsigned COORD_WIDTH_DEF  = 24;

   // register widths and reset values
   localparam int unsigned SEG_WIDTH     = 6;
   localparam logic [SEG_WIDTH-1:0] SEG_RESET = 6'd20;
   localparam logic STROKE_RESET         = 1'b1;

   // csr register map, byte address bit 2 selects the register
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic REG_SEGMENT_COUNT     = 1'b0;
   localparam logic REG_STROKE_ENABLE     = 1'b1;

   // q1.16 formats
   localparam int unsigned Q_WIDTH = 17;   // holds 0 .. 65536
   localparam int unsigned W_WIDTH = 19;   // basis weight after the factor of three
   localparam logic [Q_WIDTH-1:0] ONE_Q16 = 17'd65536;
   localparam int unsigned ROUND_SHIFT = 16;

   // number of control point coordinates in one item
   localparam int unsigned NUM_COORDS = 12;

   // control bits that travel along the pipeline with each point
   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

   // q1.16 product rounded back to q1.16, inputs at most one
   function automatic logic [Q_WIDTH-1:0] qmul(input logic [Q_WIDTH-1:0] a,
                                                input logic [Q_WIDTH-1:0] b);
      logic [2*Q_WIDTH-1:0] prod;
      prod = {{Q_WIDTH{1'b0}}, a} * {{Q_WIDTH{1'b0}}, b}
             + {{(Q_WIDTH+1){1'b0}}, 1'b1, 15'd0};
      return prod[ROUND_SHIFT +: Q_WIDTH];
   endfunction

endpackage

// ===== rtl/cbt_sequencer.sv =====
// per-curve sequencer: holds the segment count and steps t once per point
// depends on cbt_pkg; feeds cbt_weights

module cbt_sequencer #(
   parameter int unsigned MAX_SEGMENTS = 63,
   parameter int unsigned COORD_WIDTH  = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             item_valid,
   output logic                             item_ready,
   input  logic signed [COORD_WIDTH-1:0]    item_pts [12],
   input  logic [cbt_pkg::SEG_WIDTH-1:0]    segment_count,
   input  logic                             stroke_enable,
   output cbt_pkg::stage_ctl_type           out_ctl,
   output logic [cbt_pkg::Q_WIDTH-1:0]      out_t,
   output logic [cbt_pkg::Q_WIDTH-1:0]      out_u,
   output logic signed [COORD_WIDTH-1:0]    out_pts [12]
);
   import cbt_pkg::*;

   // step table: 65536 = q*n + r for every segment count from 1 to MAX_SEGMENTS
   logic [Q_WIDTH-1:0]   step_q [MAX_SEGMENTS+1];
   logic [SEG_WIDTH-1:0] step_r [MAX_SEGMENTS+1];

   for (genvar g = 0; g <= MAX_SEGMENTS; g++) begin : g_step
      localparam int unsigned Div = (g == 0) ? 1 : g;
      localparam int unsigned StepQ = 65536 / Div;
      localparam int unsigned StepR = 65536 % Div;
      assign step_q[g] = Q_WIDTH'(StepQ);
      assign step_r[g] = SEG_WIDTH'(StepR);
   end

   logic                 busy_ff, busy_in;
   logic [SEG_WIDTH-1:0] n_ff, n_in;
   logic [SEG_WIDTH-1:0] i_ff, i_in;
   logic [Q_WIDTH-1:0]   t_ff, t_in;
   logic [SEG_WIDTH-1:0] r_ff, r_in;
   logic signed [COORD_WIDTH-1:0] pts_ff [12];

   stage_ctl_type        ctl_ff, ctl_in;
   logic [Q_WIDTH-1:0]   st_ff, su_ff;
   logic signed [COORD_WIDTH-1:0] spts_ff [12];

   logic                 accept;
   logic                 issue;
   logic                 last_now;
   logic [SEG_WIDTH-1:0] n_clamp;
   logic [SEG_WIDTH:0]   r_sum;
   logic                 carry;

   assign item_ready = !busy_ff;
   assign accept     = item_valid && !busy_ff;
   assign issue      = busy_ff && advance;
   assign last_now   = (i_ff == n_ff);

   // clamp the segment count into 1 .. MAX_SEGMENTS
   always_comb begin
      if (segment_count == '0) begin
         n_clamp = SEG_WIDTH'(1);
      end else if (segment_count > SEG_WIDTH'(MAX_SEGMENTS)) begin
         n_clamp = SEG_WIDTH'(MAX_SEGMENTS);
      end else begin
         n_clamp = segment_count;
      end
   end

   // incremental t: quotient and remainder of (i*65536 + n/2) / n
   always_comb begin
      r_sum = {1'b0, r_ff} + {1'b0, step_r[n_ff]};
      carry = (r_sum >= {1'b0, n_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      n_in    = n_ff;
      i_in    = i_ff;
      t_in    = t_ff;
      r_in    = r_ff;
      if (accept) begin
         busy_in = stroke_enable;
         n_in    = n_clamp;
         i_in    = '0;
         t_in    = '0;
         r_in    = n_clamp >> 1;
      end else if (issue) begin
         busy_in = !last_now;
         i_in    = i_ff + SEG_WIDTH'(1);
         t_in    = t_ff + step_q[n_ff] + Q_WIDTH'(carry);
         r_in    = carry ? SEG_WIDTH'(r_sum - {1'b0, n_ff}) : r_sum[SEG_WIDTH-1:0];
      end
   end

   always_comb begin
      ctl_in.valid = busy_ff;
      ctl_in.last  = busy_ff && last_now;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ctl_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         if (advance) begin
            ctl_ff <= ctl_in;
         end
      end
   end

   // curve state and control points
   always_ff @(posedge clock) begin
      n_ff <= n_in;
      i_ff <= i_in;
      t_ff <= t_in;
      r_ff <= r_in;
      if (accept) begin
         pts_ff <= item_pts;
      end
   end

   // issue register, first pipeline stage
   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff   <= t_ff;
         su_ff   <= ONE_Q16 - t_ff;
         spts_ff <= pts_ff;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_t   = st_ff;
   assign out_u   = su_ff;
   assign out_pts = spts_ff;

endmodule

// ===== rtl/cbt_weights.sv =====
// bernstein basis weights in q1.16, two register stages of q1.16 products
// depends on cbt_pkg; fed by cbt_sequencer, feeds cbt_blend

module cbt_weights #(
   parameter int unsigned COORD_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  cbt_pkg::stage_ctl_type         in_ctl,
   input  logic [cbt_pkg::Q_WIDTH-1:0]    in_t,
   input  logic [cbt_pkg::Q_WIDTH-1:0]    in_u,
   input  logic signed [COORD_WIDTH-1:0]  in_pts [12],
   output cbt_pkg::stage_ctl_type         out_ctl,
   output logic [cbt_pkg::W_WIDTH-1:0]    out_w [4],
   output logic signed [COORD_WIDTH-1:0]  out_pts [12]
);
   import cbt_pkg::*;

   stage_ctl_type      a_ctl_ff, b_ctl_ff;
   logic [Q_WIDTH-1:0] a_uu_ff, a_tt_ff, a_t_ff, a_u_ff;
   logic [W_WIDTH-1:0] b_w_ff [4];
   logic signed [COORD_WIDTH-1:0] a_pts_ff [12];
   logic signed [COORD_WIDTH-1:0] b_pts_ff [12];

   logic [Q_WIDTH-1:0] m1, m2;

   assign m1 = qmul(a_uu_ff, a_t_ff);
   assign m2 = qmul(a_u_ff, a_tt_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
      end else if (advance) begin
         a_ctl_ff <= in_ctl;
         b_ctl_ff <= a_ctl_ff;
      end
   end

   // squares, then cubes and cross terms
   always_ff @(posedge clock) begin
      if (advance) begin
         a_uu_ff   <= qmul(in_u, in_u);
         a_tt_ff   <= qmul(in_t, in_t);
         a_t_ff    <= in_t;
         a_u_ff    <= in_u;
         a_pts_ff  <= in_pts;
         b_w_ff[0] <= W_WIDTH'(qmul(a_uu_ff, a_u_ff));
         b_w_ff[1] <= (W_WIDTH'(m1) << 1) + W_WIDTH'(m1);
         b_w_ff[2] <= (W_WIDTH'(m2) << 1) + W_WIDTH'(m2);
         b_w_ff[3] <= W_WIDTH'(qmul(a_tt_ff, a_t_ff));
         b_pts_ff  <= a_pts_ff;
      end
   end

   assign out_ctl = b_ctl_ff;
   assign out_w   = b_w_ff;
   assign out_pts = b_pts_ff;

endmodule

// ===== rtl/cbt_blend.sv =====
// weighted sum of the control points, rounding to q15.8 and saturation
// depends on cbt_pkg; fed by cbt_weights, holds the output register

module cbt_blend #(
   parameter int unsigned COORD_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  cbt_pkg::stage_ctl_type         in_ctl,
   input  logic [cbt_pkg::W_WIDTH-1:0]    in_w [4],
   input  logic signed [COORD_WIDTH-1:0]  in_pts [12],
   output cbt_pkg::stage_ctl_type         out_ctl,
   output logic signed [COORD_WIDTH-1:0]  out_coord [3]
);
   import cbt_pkg::*;

   localparam int unsigned PW = COORD_WIDTH + W_WIDTH + 1;   // one product
   localparam int unsigned SW = PW + 2;                      // sum of four
   localparam int unsigned RW = SW - ROUND_SHIFT;            // after rounding
   localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (COORD_WIDTH-1)) - 1);
   localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

   stage_ctl_type c_ctl_ff, d_ctl_ff, e_ctl_ff;
   logic signed [PW-1:0] c_prod_ff [3][4];
   logic signed [SW-1:0] d_sum_ff [3];
   logic signed [COORD_WIDTH-1:0] e_coord_ff [3];

   logic signed [SW-1:0] rnd [3];
   logic signed [RW-1:0] shr [3];
   logic signed [COORD_WIDTH-1:0] sat [3];

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff <= '0;
         d_ctl_ff <= '0;
         e_ctl_ff <= '0;
      end else if (advance) begin
         c_ctl_ff <= in_ctl;
         d_ctl_ff <= c_ctl_ff;
         e_ctl_ff <= d_ctl_ff;
      end
   end

   // products of weight and coordinate, one per point and axis
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 4; k++) begin
               c_prod_ff[c][k] <= $signed({1'b0, in_w[k]}) * in_pts[3*k + c];
            end
         end
      end
   end

   // sum of the four terms
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 3; c++) begin
            d_sum_ff[c] <= SW'(c_prod_ff[c][0]) + SW'(c_prod_ff[c][1])
                         + SW'(c_prod_ff[c][2]) + SW'(c_prod_ff[c][3]);
         end
      end
   end

   // round half up to q15.8, then clip to the coordinate range
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rnd[c] = d_sum_ff[c] + SW'(32768);
         shr[c] = rnd[c][SW-1:ROUND_SHIFT];
         if (shr[c] > SAT_HI) begin
            sat[c] = SAT_HI[COORD_WIDTH-1:0];
         end else if (shr[c] < SAT_LO) begin
            sat[c] = SAT_LO[COORD_WIDTH-1:0];
         end else begin
            sat[c] = shr[c][COORD_WIDTH-1:0];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (advance) begin
         e_coord_ff <= sat;
      end
   end

   assign out_ctl   = e_ctl_ff;
   assign out_coord = e_coord_ff;

endmodule

// ===== rtl/cubic_bezier_tessellator.sv =====
// top level of the cubic bezier tessellator: csr registers, stream ports, pipeline
// depends on cbt_pkg, cbt_sequencer, cbt_weights and cbt_blend
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------
//  req_     | in        | req_tvalid/req_tready | four control points, 12 coordinates
//  rsp_     | out       | rsp_tvalid/rsp_tready | one curve point, tlast on t = 1
//  csr_     | in        | apb, pready always 1  | segment_count, stroke_enable
//
// a curve gives n+1 points, n being segment_count clamped to 1 .. MAX_SEGMENTS, one per
// cycle while rsp_ does not stall; the sequencer is ready for the next item the cycle
// after issuing the last point. each point passes the issue register, weight stages a
// and b, blend stages c and d and the output register. reset is synchronous, clears the
// valid bits and loads the csr reset values. a stalled rsp_ side freezes every stage at
// once, nothing is lost or repeated. with stroke disabled an item is taken and dropped.

module cubic_bezier_tessellator #(
   parameter int unsigned MAX_SEGMENTS = cbt_pkg::MAX_SEGMENTS_DEF,
   parameter int unsigned COORD_WIDTH  = cbt_pkg::COORD_WIDTH_DEF,
   localparam int unsigned REQ_BITS    = ((12*COORD_WIDTH + 7) / 8) * 8,
   localparam int unsigned RSP_BITS    = ((3*COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, p4_x, p4_y, p4_z
   input  logic [REQ_BITS-1:0]                   req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // point_x, point_y, point_z
   output logic [RSP_BITS-1:0]                   rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [cbt_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [cbt_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [cbt_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import cbt_pkg::*;

   logic [SEG_WIDTH-1:0] seg_ff;
   logic                 stroke_ff;
   logic                 csr_write;
   logic                 advance;

   logic signed [COORD_WIDTH-1:0] req_pts [12];
   logic signed [COORD_WIDTH-1:0] s_pts [12];
   logic signed [COORD_WIDTH-1:0] w_pts [12];
   logic signed [COORD_WIDTH-1:0] coord [3];
   logic [Q_WIDTH-1:0]            s_t, s_u;
   logic [W_WIDTH-1:0]            w_w [4];
   stage_ctl_type                 s_ctl, w_ctl, o_ctl;

   // csr registers
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff    <= SEG_RESET;
         stroke_ff <= STROKE_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_SEGMENT_COUNT: seg_ff    <= csr_pwdata[SEG_WIDTH-1:0];
            REG_STROKE_ENABLE: stroke_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SEGMENT_COUNT: csr_prdata = CSR_DATA_WIDTH'(seg_ff);
         REG_STROKE_ENABLE: csr_prdata = CSR_DATA_WIDTH'(stroke_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // unpack the control points
   always_comb begin
      for (int k = 0; k < NUM_COORDS; k++) begin
         req_pts[k] = req_tdata[k*COORD_WIDTH +: COORD_WIDTH];
      end
   end

   // whole pipeline moves when the output register is free or being taken
   assign advance = !o_ctl.valid || rsp_tready;

   cbt_sequencer #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item_valid    (req_tvalid),
      .item_ready    (req_tready),
      .item_pts      (req_pts),
      .segment_count (seg_ff),
      .stroke_enable (stroke_ff),
      .out_ctl       (s_ctl),
      .out_t         (s_t),
      .out_u         (s_u),
      .out_pts       (s_pts)
   );

   cbt_weights #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_weights (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_ctl  (s_ctl),
      .in_t    (s_t),
      .in_u    (s_u),
      .in_pts  (s_pts),
      .out_ctl (w_ctl),
      .out_w   (w_w),
      .out_pts (w_pts)
   );

   cbt_blend #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctl    (w_ctl),
      .in_w      (w_w),
      .in_pts    (w_pts),
      .out_ctl   (o_ctl),
      .out_coord (coord)
   );

   // result channel
   assign rsp_tvalid = o_ctl.valid;
   assign rsp_tlast  = o_ctl.last;
   assign rsp_tdata  = RSP_BITS'({coord[2], coord[1], coord[0]});

endmodule
